>>> hw/rtl/mtpm_pkg.sv
// shared types, constants and codes of the multi-track pcm mixer
// no dependencies
`timescale 1ns / 1ps

package mtpm_pkg;

   localparam int NUM_SLOTS_DEF  = 4;
   localparam int INDEX_BITS_DEF = 24;

   localparam int SAMPLE_W      = 16;
   localparam int SAMPLE_FIELDS = 4;
   localparam int INDEX_OUT_W   = 24;
   localparam int VOL_W         = 8;
   localparam int GATE_W        = 15;
   localparam int SLOT_W        = 2;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 15;
   localparam int PIPE_STAGES   = 4;

   localparam int PERCENT_UNIT = 100;
   localparam int PROD_W       = 25;
   localparam int MAG_W        = 23;
   localparam int QUOT_W       = 17;
   localparam int THR_W        = 23;
   localparam int REM_W        = 24;
   localparam int RECIP_SHIFT  = 24;
   localparam int RECIP_MUL    = (1 << RECIP_SHIFT) / PERCENT_UNIT;
   localparam int QMUL_W       = 41;
   localparam int SAT_POS_MAG  = 32767;
   localparam int SAT_NEG_MAG  = 32768;

   localparam logic [VOL_W-1:0]  VOL_CEILING_RST    = 8'd100;
   localparam logic [VOL_W-1:0]  DEFAULT_VOLUME_RST = 8'd100;
   localparam logic [GATE_W-1:0] GATE_LEVEL_RST     = 15'd0;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_MIX  = 1'b1
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_VOL_CEILING    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_VOLUME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_LEVEL     = 2'd2;

   typedef struct packed {
      logic [VOL_W-1:0]  vol_ceiling;
      logic [VOL_W-1:0]  default_volume;
      logic [GATE_W-1:0] gate_level;
   } cfg_type;

   typedef struct packed {
      logic [SLOT_W-1:0]      slot;
      logic [INDEX_OUT_W-1:0] track_length;
      logic                   repeat_req;
      logic [VOL_W-1:0]       volume_percent;
   } load_type;

   typedef struct packed {
      logic                   load;
      logic                   mix;
      logic [PIPE_STAGES-1:0] en;
   } lane_ctl_type;

   typedef struct packed {
      logic [SAMPLE_FIELDS-1:0]                  active_mask;
      logic [SAMPLE_FIELDS-1:0][INDEX_OUT_W-1:0] next_index;
   } report_type;

endpackage

>>> hw/rtl/mtpm_if.sv
// valid/ready channel interfaces for the mixer request and response items
// depends on mtpm_pkg
`timescale 1ns / 1ps

interface mtpm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  cmd;
   logic [mtpm_pkg::SLOT_W-1:0]           slot;
   logic [mtpm_pkg::INDEX_OUT_W-1:0]      track_length;
   logic                                  repeat_req;
   logic [mtpm_pkg::VOL_W-1:0]            volume_percent;
   logic signed [mtpm_pkg::SAMPLE_W-1:0]  sample_zero;
   logic signed [mtpm_pkg::SAMPLE_W-1:0]  sample_one;
   logic signed [mtpm_pkg::SAMPLE_W-1:0]  sample_two;
   logic signed [mtpm_pkg::SAMPLE_W-1:0]  sample_three;

   modport source (
      output valid, cmd, slot, track_length, repeat_req, volume_percent,
             sample_zero, sample_one, sample_two, sample_three,
      input  ready
   );

   modport sink (
      input  valid, cmd, slot, track_length, repeat_req, volume_percent,
             sample_zero, sample_one, sample_two, sample_three,
      output ready
   );
endinterface

interface mtpm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mtpm_pkg::SAMPLE_W-1:0]     mix_word;
   logic [mtpm_pkg::INDEX_OUT_W-1:0]  next_index_zero;
   logic [mtpm_pkg::INDEX_OUT_W-1:0]  next_index_one;
   logic [mtpm_pkg::INDEX_OUT_W-1:0]  next_index_two;
   logic [mtpm_pkg::INDEX_OUT_W-1:0]  next_index_three;
   logic [mtpm_pkg::SAMPLE_FIELDS-1:0] active_mask;

   modport source (
      output valid, mix_word, next_index_zero, next_index_one, next_index_two,
             next_index_three, active_mask,
      input  ready
   );

   modport sink (
      input  valid, mix_word, next_index_zero, next_index_one, next_index_two,
             next_index_three, active_mask,
      output ready
   );
endinterface

>>> hw/rtl/multi_track_pcm_mixer.sv
// top level of the multi-track pcm mixer: csr block, lanes, pipeline control, response
// depends on mtpm_pkg, mtpm_if, mtpm_lane, mtpm_merge
// usage:
//   req_ch carries one item per handshake. a load item (cmd 0) starts a track in
//   a slot with its length, repeat flag and volume; a mix item (cmd 1) brings one
//   raw sample per slot and returns the scaled, gated, summed, byte-swapped word.
//   every item gives exactly one rsp_ch item with the slot positions and the
//   playing mask as they stand after that item; a load item returns mix word 0.
//   csr_wr_en/csr_index/csr_wr_data write the volume ceiling, default_volume and
//   gate_level; write them only while no item is in flight.
//   throughput: one item per cycle while rsp_ch does not stall. the response
//   passes the product, reciprocal divide, correction, saturate/gate and sum
//   registers in that order. track positions update at the accepting edge,
//   so back-to-back items always see current state.
//   reset: all tracks stopped, positions 0, volumes 100/100, gate 0.
//   when rsp_ch stalls, bubbles are squeezed out and req_ch.ready drops only
//   once all five pipeline registers hold items.
`timescale 1ns / 1ps

module multi_track_pcm_mixer #(
   parameter int NUM_SLOTS  = mtpm_pkg::NUM_SLOTS_DEF,
   parameter int INDEX_BITS = mtpm_pkg::INDEX_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   mtpm_req_if.sink                            req_ch,
   mtpm_rsp_if.source                          rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [mtpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mtpm_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int STAGES    = mtpm_pkg::PIPE_STAGES;
   localparam int WIDE_BITS = (INDEX_BITS > mtpm_pkg::INDEX_OUT_W) ? INDEX_BITS
                                                                     : mtpm_pkg::INDEX_OUT_W;

   mtpm_pkg::cfg_type       cfg_ff, cfg_in;
   mtpm_pkg::lane_ctl_type  lane_ctl;
   mtpm_pkg::load_type      load;
   mtpm_pkg::report_type    rpt_ff [STAGES+1];
   mtpm_pkg::report_type    rpt_in;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic              out_vld_ff, out_vld_in;
   logic [STAGES:0]   en;
   logic              accept;

   logic [mtpm_pkg::SAMPLE_FIELDS-1:0][mtpm_pkg::SAMPLE_W-1:0] samples;
   logic [NUM_SLOTS-1:0][INDEX_BITS-1:0]                       lane_index;
   logic [NUM_SLOTS-1:0]                                       lane_playing;
   logic [NUM_SLOTS-1:0][mtpm_pkg::SAMPLE_W-1:0]               lane_contrib;
   logic [mtpm_pkg::SAMPLE_W-1:0]                              mix_word;

   // csr block
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mtpm_pkg::CSR_VOL_CEILING:
               cfg_in.vol_ceiling = csr_wr_data[mtpm_pkg::VOL_W-1:0];
            mtpm_pkg::CSR_DEFAULT_VOLUME:
               cfg_in.default_volume = csr_wr_data[mtpm_pkg::VOL_W-1:0];
            mtpm_pkg::CSR_GATE_LEVEL:
               cfg_in.gate_level = csr_wr_data[mtpm_pkg::GATE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vol_ceiling    <= mtpm_pkg::VOL_CEILING_RST;
         cfg_ff.default_volume <= mtpm_pkg::DEFAULT_VOLUME_RST;
         cfg_ff.gate_level     <= mtpm_pkg::GATE_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage enables: a stage moves when empty or when the next one moves
   always_comb begin
      en[STAGES] = !out_vld_ff || rsp_ch.ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_ch.ready = en[0];
   assign accept       = req_ch.valid && en[0];

   always_comb begin
      vld_in[0] = en[0] ? req_ch.valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
      out_vld_in = en[STAGES] ? vld_ff[STAGES-1] : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // lane control and load fields
   assign lane_ctl.load = accept && (req_ch.cmd == mtpm_pkg::CMD_LOAD);
   assign lane_ctl.mix  = accept && (req_ch.cmd == mtpm_pkg::CMD_MIX);
   assign lane_ctl.en   = en[STAGES-1:0];

   assign load.slot           = req_ch.slot;
   assign load.track_length   = req_ch.track_length;
   assign load.repeat_req     = req_ch.repeat_req;
   assign load.volume_percent = req_ch.volume_percent;

   assign samples = {req_ch.sample_three, req_ch.sample_two,
                     req_ch.sample_one, req_ch.sample_zero};

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_lane
      logic signed [mtpm_pkg::SAMPLE_W-1:0] raw;
      if (i < mtpm_pkg::SAMPLE_FIELDS) begin : g_fed
         assign raw = $signed(samples[i]);
      end else begin : g_unfed
         assign raw = '0;
      end

      mtpm_lane #(
         .INDEX_BITS (INDEX_BITS),
         .LANE       (i)
      ) u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctl          (lane_ctl),
         .load         (load),
         .cfg          (cfg_ff),
         .raw_sample   (raw),
         .next_index   (lane_index[i]),
         .next_playing (lane_playing[i]),
         .contrib      (lane_contrib[i])
      );
   end

   // reported positions and mask, snapshot at the accepting edge
   for (genvar j = 0; j < mtpm_pkg::SAMPLE_FIELDS; j++) begin : g_report
      if (j < NUM_SLOTS) begin : g_live
         logic [WIDE_BITS-1:0] wide;
         assign wide                  = WIDE_BITS'(lane_index[j]);
         assign rpt_in.next_index[j]  = wide[mtpm_pkg::INDEX_OUT_W-1:0];
         assign rpt_in.active_mask[j] = lane_playing[j];
      end else begin : g_none
         assign rpt_in.next_index[j]  = '0;
         assign rpt_in.active_mask[j] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rpt_ff[0] <= rpt_in;
      end
      for (int k = 1; k <= STAGES; k++) begin
         if (en[k]) begin
            rpt_ff[k] <= rpt_ff[k-1];
         end
      end
   end

   mtpm_merge #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_merge (
      .clock    (clock),
      .load_en  (en[STAGES]),
      .contrib  (lane_contrib),
      .mix_word (mix_word)
   );

   assign rsp_ch.valid            = out_vld_ff;
   assign rsp_ch.mix_word         = mix_word;
   assign rsp_ch.next_index_zero  = rpt_ff[STAGES].next_index[0];
   assign rsp_ch.next_index_one   = rpt_ff[STAGES].next_index[1];
   assign rsp_ch.next_index_two   = rpt_ff[STAGES].next_index[2];
   assign rsp_ch.next_index_three = rpt_ff[STAGES].next_index[3];
   assign rsp_ch.active_mask      = rpt_ff[STAGES].active_mask;

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> ((&vld_ff) && out_vld_ff))
      else $error("input stalled with room in the pipeline");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> vld_ff[0])
      else $error("accepted item missing from first stage");

   a_rsp_from_last_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(vld_ff[STAGES-1]))
      else $error("response appeared without an item in the last stage");

endmodule

>>> hw/rtl/mtpm_lane.sv
// one track slot: play state, position counter and the scale/saturate/gate pipeline
// depends on mtpm_pkg
`timescale 1ns / 1ps

module mtpm_lane #(
   parameter int INDEX_BITS = mtpm_pkg::INDEX_BITS_DEF,
   parameter int LANE       = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mtpm_pkg::lane_ctl_type                ctl,
   input  mtpm_pkg::load_type                    load,
   input  mtpm_pkg::cfg_type                     cfg,
   input  logic signed [mtpm_pkg::SAMPLE_W-1:0]  raw_sample,
   output logic [INDEX_BITS-1:0]                 next_index,
   output logic                                  next_playing,
   output logic [mtpm_pkg::SAMPLE_W-1:0]         contrib
);

   logic [INDEX_BITS-1:0]       index_ff, index_in, length_ff, length_in, index_inc;
   logic                        playing_ff, playing_in, loop_ff, loop_in;
   logic [mtpm_pkg::VOL_W-1:0]  gain_ff, gain_in;
   logic                        hit, step;

   logic signed [mtpm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                               act1_ff;
   logic [mtpm_pkg::VOL_W-1:0]         gain1_ff;

   logic [mtpm_pkg::PROD_W-1:0]  abs_val;
   logic [mtpm_pkg::QMUL_W-1:0]  qmul;
   logic [mtpm_pkg::MAG_W-1:0]   mag2_ff, mag2_in;
   logic [mtpm_pkg::QUOT_W-1:0]  qest2_ff;
   logic [mtpm_pkg::THR_W-1:0]   thr2_ff;
   logic                         neg2_ff, act2_ff;

   logic [mtpm_pkg::REM_W-1:0]   rem;
   logic [mtpm_pkg::QUOT_W-1:0]  quot3_ff, quot3_in;
   logic [mtpm_pkg::THR_W-1:0]   thr3_ff;
   logic                         neg3_ff, act3_ff;

   logic [mtpm_pkg::SAMPLE_W-1:0] sat_mag, contrib4_ff, contrib4_in;
   logic                          gate_pass;

   // track state update at the accepting edge
   assign hit       = ctl.load && (32'(load.slot) == 32'(LANE));
   assign step      = ctl.mix && playing_ff;
   assign index_inc = index_ff + INDEX_BITS'(1);

   always_comb begin
      index_in   = index_ff;
      length_in  = length_ff;
      playing_in = playing_ff;
      loop_in    = loop_ff;
      gain_in    = gain_ff;
      if (hit) begin
         length_in  = INDEX_BITS'(load.track_length);
         loop_in    = load.repeat_req;
         gain_in    = (load.volume_percent < cfg.vol_ceiling) ? load.volume_percent
                                                               : cfg.default_volume;
         index_in   = '0;
         playing_in = 1'b1;
      end else if (step) begin
         if (index_inc >= length_ff) begin
            index_in = '0;
            if (!loop_ff) begin
               playing_in = 1'b0;
            end
         end else begin
            index_in = index_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= '0;
         playing_ff <= 1'b0;
         loop_ff    <= 1'b0;
      end else begin
         index_ff   <= index_in;
         playing_ff <= playing_in;
         loop_ff    <= loop_in;
      end
   end

   always_ff @(posedge clock) begin
      length_ff <= length_in;
      gain_ff   <= gain_in;
   end

   assign next_index   = index_in;
   assign next_playing = playing_in;

   // stage 1: sample times gain
   assign prod_in = mtpm_pkg::PROD_W'(raw_sample)
                    * mtpm_pkg::PROD_W'($signed({1'b0, gain_ff}));

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         prod_ff  <= prod_in;
         act1_ff  <= step;
         gain1_ff <= gain_ff;
      end
   end

   // stage 2: magnitude, reciprocal estimate of /100, gate threshold
   assign abs_val = prod_ff[mtpm_pkg::PROD_W-1] ? mtpm_pkg::PROD_W'(-prod_ff)
                                                : mtpm_pkg::PROD_W'(prod_ff);
   assign mag2_in = abs_val[mtpm_pkg::MAG_W-1:0];
   assign qmul    = mtpm_pkg::QMUL_W'(mag2_in) * mtpm_pkg::QMUL_W'(mtpm_pkg::RECIP_MUL);

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         mag2_ff  <= mag2_in;
         qest2_ff <= qmul[mtpm_pkg::RECIP_SHIFT +: mtpm_pkg::QUOT_W];
         thr2_ff  <= mtpm_pkg::THR_W'(gain1_ff) * mtpm_pkg::THR_W'(cfg.gate_level);
         neg2_ff  <= prod_ff[mtpm_pkg::PROD_W-1];
         act2_ff  <= act1_ff;
      end
   end

   // stage 3: quotient correction, estimate is at most one low
   assign rem = mtpm_pkg::REM_W'(mag2_ff)
                - mtpm_pkg::REM_W'(qest2_ff) * mtpm_pkg::REM_W'(mtpm_pkg::PERCENT_UNIT);
   assign quot3_in = (rem >= mtpm_pkg::REM_W'(mtpm_pkg::PERCENT_UNIT))
                     ? qest2_ff + mtpm_pkg::QUOT_W'(1) : qest2_ff;

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         quot3_ff <= quot3_in;
         thr3_ff  <= thr2_ff;
         neg3_ff  <= neg2_ff;
         act3_ff  <= act2_ff;
      end
   end

   // stage 4: saturate, noise gate, restore sign
   always_comb begin
      if (neg3_ff) begin
         sat_mag = (quot3_ff > mtpm_pkg::QUOT_W'(mtpm_pkg::SAT_NEG_MAG))
                   ? mtpm_pkg::SAMPLE_W'(mtpm_pkg::SAT_NEG_MAG)
                   : quot3_ff[mtpm_pkg::SAMPLE_W-1:0];
      end else begin
         sat_mag = (quot3_ff > mtpm_pkg::QUOT_W'(mtpm_pkg::SAT_POS_MAG))
                   ? mtpm_pkg::SAMPLE_W'(mtpm_pkg::SAT_POS_MAG)
                   : quot3_ff[mtpm_pkg::SAMPLE_W-1:0];
      end
   end

   assign gate_pass = (mtpm_pkg::THR_W'(sat_mag) * mtpm_pkg::THR_W'(mtpm_pkg::PERCENT_UNIT))
                      > thr3_ff;
   assign contrib4_in = (act3_ff && gate_pass)
                        ? (neg3_ff ? mtpm_pkg::SAMPLE_W'(~sat_mag + 16'd1) : sat_mag)
                        : '0;

   always_ff @(posedge clock) begin
      if (ctl.en[3]) begin
         contrib4_ff <= contrib4_in;
      end
   end

   assign contrib = contrib4_ff;

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (playing_ff && (length_ff != '0)) |-> (index_ff < length_ff))
      else $error("playing track index beyond its length");

   a_load_rewinds: assert property (@(posedge clock) disable iff (reset)
      hit |=> (playing_ff && (index_ff == '0)))
      else $error("loaded track not started at index zero");

endmodule

>>> hw/rtl/mtpm_merge.sv
// merging stage: sums the lane contributions with 16-bit wrap and byte-swaps the sum
// depends on mtpm_pkg
`timescale 1ns / 1ps

module mtpm_merge #(
   parameter int NUM_SLOTS = mtpm_pkg::NUM_SLOTS_DEF
) (
   input  logic                                         clock,
   input  logic                                         load_en,
   input  logic [NUM_SLOTS-1:0][mtpm_pkg::SAMPLE_W-1:0] contrib,
   output logic [mtpm_pkg::SAMPLE_W-1:0]                mix_word
);

   logic [mtpm_pkg::SAMPLE_W-1:0] sum;
   logic [mtpm_pkg::SAMPLE_W-1:0] mix_word_ff, mix_word_in;

   always_comb begin
      sum = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         sum = sum + contrib[i];
      end
   end

   assign mix_word_in = {sum[7:0], sum[15:8]};

   always_ff @(posedge clock) begin
      if (load_en) begin
         mix_word_ff <= mix_word_in;
      end
   end

   assign mix_word = mix_word_ff;

endmodule
